// ===== design/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, sequencer state, result word and phase constants.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_ACK   = 3'd5,
      OP_NACK  = 3'd6,
      OP_CHECK = 3'd7
   } op_type;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
   localparam logic [4:0]  BYTE_PHASES       = 5'd16;

   typedef struct packed {
      op_type      cmd;
      logic [4:0]  phase;
      logic [15:0] tick;
      logic [7:0]  shift;
      logic [7:0]  received;
      logic        scl;
      logic        sda;
      logic        ack;
   } state_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       cmd_done;
      logic [7:0] rx_byte;
      logic       ack_ok;
      logic       cmd_error;
   } result_type;

endpackage

// ===== design/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Drives SCL and SDA phase by phase for start, stop, byte and ack commands.
//
// Usage:
//   req_* carries one word: an op (tick or command), a byte to send and the
//   sensed SDA level. Each accepted word gives exactly one rsp_* word with the
//   pin drives, busy, done, received byte, ack result and error flag.
//   A command sets its first phase at once; each phase then lasts phase_ticks
//   tick words (zero counts as one). A command while busy is flagged.
//   csr_wr_en / csr_wr_data write phase_ticks; write only while idle.
// Timing:
//   From acceptance to rsp_valid a word passes an input register, then the
//   sequencer update into the state and result registers. One word per cycle
//   sustained while rsp_stall is low; the state update is one pass per word.
// Reset:
//   Synchronous. Both pipeline stages empty, sequencer idle, both lines
//   released, phase_ticks back to 10.
// Stall:
//   A result held under rsp_stall freezes the update stage; an empty input
//   register still takes one more word, then req_stall rises.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic        rsp_cmd_done,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_ok,
   output logic        rsp_cmd_error,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                   in_valid_ff;
   logic [2:0]             in_op_ff;
   logic [7:0]             in_tx_ff;
   logic                   in_sda_ff;
   logic [15:0]            phase_ticks_ff;
   i2cmbs_pkg::state_type  state_ff;
   i2cmbs_pkg::state_type  state_in;
   i2cmbs_pkg::result_type res_in;
   i2cmbs_pkg::result_type res_ff;
   logic                   rsp_valid_ff;
   logic                   advance;
   logic                   take;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   i2cmbs_step u_step (
      .cur         (state_ff),
      .op          (i2cmbs_pkg::op_type'(in_op_ff)),
      .tx_byte     (in_tx_ff),
      .sda_in      (in_sda_ff),
      .phase_ticks (phase_ticks_ff),
      .nxt         (state_in),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cmbs_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_valid;
      end
      if (take) begin
         in_op_ff <= req_op;
         in_tx_ff <= req_tx_byte;
         in_sda_ff <= req_sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cmd      <= i2cmbs_pkg::OP_TICK;
         state_ff.phase    <= 5'd0;
         state_ff.tick     <= 16'd0;
         state_ff.shift    <= 8'd0;
         state_ff.received <= 8'd0;
         state_ff.scl      <= 1'b1;
         state_ff.sda      <= 1'b1;
         state_ff.ack      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = res_ff.scl_level;
   assign rsp_sda_level = res_ff.sda_level;
   assign rsp_busy_res  = res_ff.busy_res;
   assign rsp_cmd_done  = res_ff.cmd_done;
   assign rsp_rx_byte   = res_ff.rx_byte;
   assign rsp_ack_ok    = res_ff.ack_ok;
   assign rsp_cmd_error = res_ff.cmd_error;

`ifndef SYNTHESIS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_done |-> !rsp_busy_res)
      else $error("command done while still busy");

   a_err_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_error |-> rsp_busy_res && !rsp_cmd_done)
      else $error("error word not busy or also done");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && in_valid_ff)
      else $error("input stalled without a held result");

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> state_ff.phase == 5'd0)
      else $error("phase index left nonzero when idle");
`endif

endmodule

// ===== design/i2cmbs_step.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer step
// Next-state and result logic for one word: command launch, tick counting,
// phase advance, sampling and pin settings.
// ----------------------------------------------------------------------------
module i2cmbs_step (
   input  i2cmbs_pkg::state_type  cur,
   input  i2cmbs_pkg::op_type     op,
   input  logic [7:0]             tx_byte,
   input  logic                   sda_in,
   input  logic [15:0]            phase_ticks,
   output i2cmbs_pkg::state_type  nxt,
   output i2cmbs_pkg::result_type res
);

   function automatic logic [4:0] phase_total(i2cmbs_pkg::op_type c);
      case (c)
         i2cmbs_pkg::OP_START: phase_total = 5'd3;
         i2cmbs_pkg::OP_STOP:  phase_total = 5'd3;
         i2cmbs_pkg::OP_WRITE: phase_total = 5'd17;
         i2cmbs_pkg::OP_READ:  phase_total = 5'd17;
         i2cmbs_pkg::OP_ACK:   phase_total = 5'd2;
         i2cmbs_pkg::OP_NACK:  phase_total = 5'd2;
         i2cmbs_pkg::OP_CHECK: phase_total = 5'd1;
         default:              phase_total = 5'd0;
      endcase
   endfunction

   // pins for phase p; returns {scl, sda}
   function automatic logic [1:0] phase_pins(i2cmbs_pkg::op_type c, logic [4:0] p,
                                             logic [7:0] sh, logic scl, logic sda);
      logic s_c;
      logic s_d;
      s_c = scl;
      s_d = sda;
      case (c)
         i2cmbs_pkg::OP_START: begin
            if (p == 5'd0) begin
               s_d = 1'b1;
               s_c = 1'b1;
            end else if (p == 5'd1) begin
               s_d = 1'b0;
            end else begin
               s_c = 1'b0;
            end
         end
         i2cmbs_pkg::OP_STOP: begin
            if (p == 5'd0) begin
               s_d = 1'b0;
               s_c = 1'b1;
            end else if (p == 5'd1) begin
               s_d = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         i2cmbs_pkg::OP_WRITE: begin
            if (p >= i2cmbs_pkg::BYTE_PHASES) begin
               s_d = 1'b1;
               s_c = 1'b0;
            end else if (!p[0]) begin
               s_d = sh[7];
               s_c = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         i2cmbs_pkg::OP_READ: begin
            s_c = p[0];
         end
         i2cmbs_pkg::OP_ACK: begin
            if (p == 5'd0) begin
               s_d = 1'b0;
               s_c = 1'b1;
            end else begin
               s_c = 1'b0;
               s_d = 1'b1;
            end
         end
         i2cmbs_pkg::OP_NACK: begin
            if (p == 5'd0) begin
               s_d = 1'b1;
               s_c = 1'b1;
            end else begin
               s_c = 1'b0;
            end
         end
         i2cmbs_pkg::OP_CHECK: begin
            s_d = 1'b1;
            s_c = 1'b1;
         end
         default: begin
         end
      endcase
      phase_pins = {s_c, s_d};
   endfunction

   logic [15:0] pt_eff;
   logic [16:0] tick_inc;
   logic [4:0]  phase_inc;
   logic [7:0]  shift_end;
   logic [1:0]  pins;
   logic        err;
   logic        done;

   assign pt_eff    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
   assign tick_inc  = {1'b0, cur.tick} + 17'd1;
   assign phase_inc = cur.phase + 5'd1;

   always_comb begin
      shift_end = cur.shift;
      if (cur.cmd == i2cmbs_pkg::OP_WRITE && cur.phase < i2cmbs_pkg::BYTE_PHASES
          && cur.phase[0]) begin
         shift_end = {cur.shift[6:0], 1'b0};
      end else if (cur.cmd == i2cmbs_pkg::OP_READ && cur.phase[0]) begin
         shift_end = {cur.shift[6:0], sda_in};
      end
   end

   always_comb begin
      nxt  = cur;
      err  = 1'b0;
      done = 1'b0;
      pins = 2'b00;
      if (op != i2cmbs_pkg::OP_TICK) begin
         if (cur.cmd != i2cmbs_pkg::OP_TICK) begin
            err = 1'b1;
         end else begin
            nxt.cmd   = op;
            nxt.phase = 5'd0;
            nxt.tick  = 16'd0;
            if (op == i2cmbs_pkg::OP_WRITE) begin
               nxt.shift = tx_byte;
            end
            if (op == i2cmbs_pkg::OP_READ) begin
               nxt.shift = 8'd0;
            end
            pins    = phase_pins(op, 5'd0, nxt.shift, cur.scl, cur.sda);
            nxt.scl = pins[1];
            nxt.sda = pins[0];
         end
      end else if (cur.cmd != i2cmbs_pkg::OP_TICK) begin
         if (tick_inc >= {1'b0, pt_eff}) begin
            nxt.tick  = 16'd0;
            nxt.shift = shift_end;
            if (cur.cmd == i2cmbs_pkg::OP_CHECK) begin
               nxt.ack = ~sda_in;
            end
            if (phase_inc >= phase_total(cur.cmd)) begin
               if (cur.cmd == i2cmbs_pkg::OP_CHECK) begin
                  nxt.scl = 1'b0;
               end
               if (cur.cmd == i2cmbs_pkg::OP_READ) begin
                  nxt.received = shift_end;
               end
               nxt.cmd   = i2cmbs_pkg::OP_TICK;
               nxt.phase = 5'd0;
               done      = 1'b1;
            end else begin
               nxt.phase = phase_inc;
               pins      = phase_pins(cur.cmd, phase_inc, shift_end, cur.scl, cur.sda);
               nxt.scl   = pins[1];
               nxt.sda   = pins[0];
            end
         end else begin
            nxt.tick = tick_inc[15:0];
         end
      end
   end

   always_comb begin
      res.scl_level = nxt.scl;
      res.sda_level = nxt.sda;
      res.busy_res  = (nxt.cmd != i2cmbs_pkg::OP_TICK);
      res.cmd_done  = done;
      res.rx_byte   = nxt.received;
      res.ack_ok    = nxt.ack;
      res.cmd_error = err;
   end

endmodule

// ===== tb/i2c_master_bit_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Feeds tick and command words in random bursts while the result side stalls
// on its own pattern. A built-in sequencer model predicts every result word,
// which is checked field by field in arrival order. phase_ticks is retuned
// between traffic phases, covering the reset value, zero, one and 65535.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      i2cmbs_pkg::op_type op;
      logic [7:0]         tx;
      logic               sda;
   } bus_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = 3'd0;
   logic [7:0]  req_tx_byte = 8'd0;
   logic        req_sda_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic        rsp_cmd_done;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_ok;
   logic        rsp_cmd_error;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   bus_word_type           word_queue[$];
   i2cmbs_pkg::result_type expected_results[$];
   int                     mismatch_total = 0;

   // sequencer model state
   i2cmbs_pkg::op_type seq_cmd;
   int                 seq_phase;
   int                 seq_tick;
   logic [7:0]         seq_shift;
   logic [7:0]         seq_rx;
   logic               seq_scl;
   logic               seq_sda;
   logic               seq_ack;
   logic [15:0]        ticks_cfg;

   int burst_left;
   int gap_left;
   int stall_left;
   int stall_pct;
   int idle_cycles = 0;

   i2c_master_bit_sequencer dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_tx_byte   (req_tx_byte),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_level (rsp_sda_level),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_cmd_done  (rsp_cmd_done),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_ok    (rsp_ack_ok),
      .rsp_cmd_error (rsp_cmd_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int phase_count(i2cmbs_pkg::op_type op);
      case (op)
         i2cmbs_pkg::OP_START, i2cmbs_pkg::OP_STOP: return 3;
         i2cmbs_pkg::OP_WRITE, i2cmbs_pkg::OP_READ: return int'(i2cmbs_pkg::BYTE_PHASES) + 1;
         i2cmbs_pkg::OP_ACK, i2cmbs_pkg::OP_NACK:   return 2;
         i2cmbs_pkg::OP_CHECK:                      return 1;
         default:                                   return 0;
      endcase
   endfunction

   task automatic drive_phase_pins();
      case (seq_cmd)
         i2cmbs_pkg::OP_START: begin
            if (seq_phase == 0) begin
               seq_sda = 1'b1;
               seq_scl = 1'b1;
            end else if (seq_phase == 1) begin
               seq_sda = 1'b0;
            end else begin
               seq_scl = 1'b0;
            end
         end
         i2cmbs_pkg::OP_STOP: begin
            if (seq_phase == 0) begin
               seq_sda = 1'b0;
               seq_scl = 1'b1;
            end else if (seq_phase == 1) begin
               seq_sda = 1'b1;
            end else begin
               seq_scl = 1'b0;
            end
         end
         i2cmbs_pkg::OP_WRITE: begin
            if (seq_phase >= int'(i2cmbs_pkg::BYTE_PHASES)) begin
               seq_sda = 1'b1;
               seq_scl = 1'b0;
            end else if (seq_phase % 2 == 0) begin
               seq_sda = seq_shift[7];
               seq_scl = 1'b1;
            end else begin
               seq_scl = 1'b0;
            end
         end
         i2cmbs_pkg::OP_READ: seq_scl = (seq_phase % 2 == 1);
         i2cmbs_pkg::OP_ACK: begin
            seq_scl = (seq_phase == 0);
            seq_sda = (seq_phase != 0);
         end
         i2cmbs_pkg::OP_NACK: begin
            if (seq_phase == 0) begin
               seq_sda = 1'b1;
               seq_scl = 1'b1;
            end else begin
               seq_scl = 1'b0;
            end
         end
         i2cmbs_pkg::OP_CHECK: begin
            seq_sda = 1'b1;
            seq_scl = 1'b1;
         end
         default: ;
      endcase
   endtask

   task automatic step_sequencer(input i2cmbs_pkg::op_type op, input logic [7:0] tx,
                                 input logic sda, output i2cmbs_pkg::result_type r);
      int span;
      r = '0;
      if (op != i2cmbs_pkg::OP_TICK) begin
         if (seq_cmd != i2cmbs_pkg::OP_TICK) begin
            r.cmd_error = 1'b1;
         end else begin
            seq_cmd = op;
            seq_phase = 0;
            seq_tick = 0;
            if (op == i2cmbs_pkg::OP_WRITE) seq_shift = tx;
            if (op == i2cmbs_pkg::OP_READ) seq_shift = 8'd0;
            drive_phase_pins();
         end
      end else if (seq_cmd != i2cmbs_pkg::OP_TICK) begin
         span = (ticks_cfg == 16'd0) ? 1 : int'(ticks_cfg);
         seq_tick++;
         if (seq_tick >= span) begin
            seq_tick = 0;
            if (seq_cmd == i2cmbs_pkg::OP_WRITE && seq_phase < int'(i2cmbs_pkg::BYTE_PHASES)
                && seq_phase % 2 == 1)
               seq_shift = seq_shift << 1;
            else if (seq_cmd == i2cmbs_pkg::OP_READ && seq_phase % 2 == 1)
               seq_shift = {seq_shift[6:0], sda};
            else if (seq_cmd == i2cmbs_pkg::OP_CHECK)
               seq_ack = ~sda;
            seq_phase++;
            if (seq_phase >= phase_count(seq_cmd)) begin
               if (seq_cmd == i2cmbs_pkg::OP_CHECK) seq_scl = 1'b0;
               if (seq_cmd == i2cmbs_pkg::OP_READ) seq_rx = seq_shift;
               seq_cmd = i2cmbs_pkg::OP_TICK;
               seq_phase = 0;
               r.cmd_done = 1'b1;
            end else begin
               drive_phase_pins();
            end
         end
      end
      r.scl_level = seq_scl;
      r.sda_level = seq_sda;
      r.busy_res  = (seq_cmd != i2cmbs_pkg::OP_TICK);
      r.rx_byte   = seq_rx;
      r.ack_ok    = seq_ack;
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_total++;
      end
   endfunction

   // sender: bursts of words with random gaps
   always @(posedge clock) begin : feed
      bus_word_type           w;
      i2cmbs_pkg::result_type r;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
         seq_cmd = i2cmbs_pkg::OP_TICK;
         seq_phase = 0;
         seq_tick = 0;
         seq_shift = 8'd0;
         seq_rx = 8'd0;
         seq_scl = 1'b1;
         seq_sda = 1'b1;
         seq_ack = 1'b0;
         ticks_cfg = i2cmbs_pkg::PHASE_TICKS_RESET;
      end else begin
         if (csr_wr_en) ticks_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            step_sequencer(i2cmbs_pkg::op_type'(req_op), req_tx_byte, req_sda_in, r);
            expected_results.push_back(r);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || word_queue.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               w = word_queue.pop_front();
               req_valid <= 1'b1;
               req_op <= w.op;
               req_tx_byte <= w.tx;
               req_sda_in <= w.sda;
               if (burst_left == 0) burst_left = $urandom_range(1, 40);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: checks words and stalls in segments of varying density
   always @(posedge clock) begin : sink
      i2cmbs_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         stall_pct = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("scl_level", want.scl_level, rsp_scl_level);
               check_field("sda_level", want.sda_level, rsp_sda_level);
               check_field("busy_res", want.busy_res, rsp_busy_res);
               check_field("cmd_done", want.cmd_done, rsp_cmd_done);
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("ack_ok", want.ack_ok, rsp_ack_ok);
               check_field("cmd_error", want.cmd_error, rsp_cmd_error);
            end
         end
         if (stall_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: stall_pct = 0;
               4, 5, 6:    stall_pct = 25;
               7, 8:       stall_pct = 60;
               default:    stall_pct = 100;
            endcase
            stall_left = (stall_pct == 100) ? $urandom_range(1, 12) : $urandom_range(1, 30);
         end
         stall_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** i2c_master_bit_sequencer: FAILED **");
            $finish;
         end
      end
   end

   task automatic push_word(input i2cmbs_pkg::op_type op, input logic [7:0] tx,
                            input logic sda);
      bus_word_type w;
      w.op = op;
      w.tx = tx;
      w.sda = sda;
      word_queue.push_back(w);
   endtask

   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++)
         push_word(i2cmbs_pkg::OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   // mostly complete command sequences, some cut short, stray commands and idle ticks
   task automatic queue_random_traffic(input int n_words, input int ticks_per_phase);
      int                 added;
      int                 roll;
      int                 ticks;
      i2cmbs_pkg::op_type cmd;
      added = 0;
      while (added < n_words) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            push_word(i2cmbs_pkg::op_type'(3'($urandom_range(0, 7))), 8'($urandom),
                      1'($urandom));
            added++;
         end else begin
            cmd = i2cmbs_pkg::op_type'(3'($urandom_range(1, 7)));
            push_word(cmd, 8'($urandom), 1'($urandom));
            ticks = ticks_per_phase * phase_count(cmd);
            if (roll < 14) ticks = $urandom_range(0, ticks);
            for (int i = 0; i < ticks; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  push_word(i2cmbs_pkg::op_type'(3'($urandom_range(1, 7))), 8'($urandom),
                            1'($urandom));
                  added++;
               end
               push_ticks(1);
            end
            added += ticks + 1;
         end
      end
   endtask

   task automatic wait_until_idle();
      do @(negedge clock);
      while (word_queue.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic retune_phase_ticks(input logic [15:0] value);
      wait_until_idle();
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] pattern;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_random_traffic(300, int'(i2cmbs_pkg::PHASE_TICKS_RESET));

      // directed: one tick per phase
      retune_phase_ticks(16'd1);
      push_word(i2cmbs_pkg::OP_TICK, 8'hFF, 1'b0);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b1);
      push_word(i2cmbs_pkg::OP_START, 8'h00, 1'b0);
      push_ticks(3);
      push_word(i2cmbs_pkg::OP_WRITE, 8'hFF, 1'b0);
      push_ticks(5);
      push_word(i2cmbs_pkg::OP_STOP, 8'h00, 1'b0);
      push_ticks(12);
      push_word(i2cmbs_pkg::OP_WRITE, 8'h00, 1'b1);
      push_ticks(17);
      pattern = 8'hA5;
      push_word(i2cmbs_pkg::OP_READ, 8'h00, 1'b0);
      for (int k = 0; k <= 16; k++)
         push_word(i2cmbs_pkg::OP_TICK, 8'($urandom),
                   (k % 2 == 1) ? pattern[7 - (k - 1) / 2] : 1'($urandom));
      push_word(i2cmbs_pkg::OP_READ, 8'h00, 1'b0);
      for (int k = 0; k <= 16; k++)
         push_word(i2cmbs_pkg::OP_TICK, 8'($urandom), 1'b1);
      push_word(i2cmbs_pkg::OP_CHECK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_CHECK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b1);
      push_word(i2cmbs_pkg::OP_ACK, 8'h00, 1'b0);
      push_ticks(2);
      push_word(i2cmbs_pkg::OP_NACK, 8'h00, 1'b0);
      push_ticks(2);
      push_word(i2cmbs_pkg::OP_STOP, 8'h00, 1'b0);
      push_ticks(3);
      queue_random_traffic(300, 1);

      // zero behaves as one tick per phase
      retune_phase_ticks(16'd0);
      queue_random_traffic(300, 1);

      retune_phase_ticks(16'd3);
      queue_random_traffic(300, 3);

      retune_phase_ticks(16'd2);
      queue_random_traffic(200, 2);

      // longest phase: a check ack left part way through its phase
      retune_phase_ticks(16'hFFFF);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_CHECK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_STOP, 8'h00, 1'b0);
      push_ticks(20);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b0);
      push_word(i2cmbs_pkg::OP_TICK, 8'h00, 1'b1);

      wait_until_idle();
      repeat (5) @(posedge clock);
      if (expected_results.size() != 0)
         $error("%0d result words never arrived", expected_results.size());
      if (mismatch_total == 0 && expected_results.size() == 0) begin
         $display("** i2c_master_bit_sequencer: PASSED **");
      end else begin
         $display("** i2c_master_bit_sequencer: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/i2cmbs_pkg.sv
design/i2cmbs_step.sv
design/i2c_master_bit_sequencer.sv
tb/i2c_master_bit_sequencer_tb.sv
